// File: rtl/core/sssc_pkg.sv
// Seven-segment scan controller: shared package.
// Holds opcode, mode and register index codes and the reset values of the
// configuration registers. No dependencies.
package sssc_pkg;

    typedef enum logic [3:0] {
        OP_TICK        = 4'd0,
        OP_WRITE_DIGIT = 4'd1,
        OP_WRITE_SLIDE = 4'd2,
        OP_TIMED       = 4'd3,
        OP_SLIDE_ONCE  = 4'd4,
        OP_SLIDE_LOOP  = 4'd5,
        OP_SELECT      = 4'd6,
        OP_BLINK       = 4'd7,
        OP_CLEAR       = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        MODE_SHOW   = 3'd0,
        MODE_TIMED  = 3'd1,
        MODE_LOOP   = 3'd2,
        MODE_ONCE   = 3'd3,
        MODE_SELECT = 3'd4,
        MODE_BLINK  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        CFG_BRIGHTNESS  = 2'd0,
        CFG_SCAN_TICKS  = 2'd1,
        CFG_SLIDE_TICKS = 2'd2,
        CFG_BLINK_TICKS = 2'd3
    } cfg_t;

    localparam int OPCODE_W   = 4;
    localparam int POSITION_W = 5;
    localparam int PATTERN_W  = 8;
    localparam int AMOUNT_W   = 16;
    localparam int MODE_W     = 3;

    localparam logic [6:0]  BRIGHT_MAX        = 7'd100;
    localparam logic [6:0]  BRIGHT_RESET      = 7'd100;
    localparam logic [7:0]  SCAN_TICKS_RESET  = 8'd3;
    localparam logic [15:0] SLIDE_TICKS_RESET = 16'd250;
    localparam logic [15:0] BLINK_TICKS_RESET = 16'd500;
    localparam logic [14:0] DUTY_PROD_RESET   = 15'd300;

    // floor(p / 100) == (p * 5243) >> 19 holds exactly for p up to 100 * 255
    localparam logic [12:0] DUTY_RECIP = 13'd5243;
    localparam int          DUTY_SHIFT = 19;

endpackage

// File: rtl/core/sssc_ram.sv
// Seven-segment scan controller: generic single-port-write RAM.
// One write port and one read port with registered read data. No dependencies.
module sssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/seven_segment_scan_controller_unit.sv
// Seven-segment scan controller: top level.
// Depends on sssc_pkg and sssc_ram.
//
// Usage:
//   Input stream (s_axis_*): one item per tick or command; tuser carries the
//   opcode, tdata the position, pattern and amount. Every item, tick or
//   command, returns exactly one result item on the output stream (m_axis_*)
//   carrying the selected digit, the segment lines and the active mode.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); write
//   only while no result is outstanding.
// Latency and throughput:
//   An item is processed in the cycle it is accepted; its result is valid on
//   the following cycle. One item per cycle is sustained while the receiver
//   takes each result. The slide buffer RAM is read at the next slide
//   position, so the entry a tick needs already waits in the read register.
// Reset:
//   rst_n clears all digits, the mode goes to show and the registers return to
//   brightness 100, scan 3, slide 250, blink 500 ticks. The slide buffer is
//   not cleared. The output register is empty after reset.
// Stall:
//   While a result waits, a new item is still taken if the receiver takes the
//   waiting result in the same cycle; otherwise tready stays low.
module seven_segment_scan_controller_unit #(
    parameter int DIGITS      = 4,
    parameter int SLIDE_DEPTH = 32,
    localparam int DIGIT_W    = $clog2(DIGITS),
    localparam int OUT_W      = ((DIGIT_W + 8 + 3 + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    // slave side
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,  // position[4:0], pattern[12:5], amount[28:13]
    input  logic [3:0]       s_axis_tuser,  // opcode[3:0]
    // master side
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,  // digit_select, segment_drive, mode_now
    // configuration
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_wdata
);

    import sssc_pkg::*;

    localparam int SLIDE_AW = $clog2(SLIDE_DEPTH);
    localparam int SLEN_W   = $clog2(SLIDE_DEPTH + 1);
    localparam int SPOS_W   = $clog2(SLIDE_DEPTH + DIGITS + 1);

    // input fields
    op_t                   opcode;
    logic [POSITION_W-1:0] position;
    logic [PATTERN_W-1:0]  pattern;
    logic [AMOUNT_W-1:0]   amount;
    logic                  accept;
    logic [DIGIT_W-1:0]    pos_clamped;

    // configuration
    logic [6:0]  bright_reg, bright_next;
    logic [7:0]  scan_ticks_reg, scan_ticks_next;
    logic [15:0] slide_ticks_reg, slide_ticks_next;
    logic [15:0] blink_ticks_reg, blink_ticks_next;
    logic [14:0] prod_reg, prod_next;
    logic [6:0]  bright_wr;
    logic [27:0] duty_full;
    logic [7:0]  duty_reload;

    // state
    logic [PATTERN_W-1:0] digits_reg [DIGITS];
    logic [PATTERN_W-1:0] digits_next [DIGITS];
    mode_t                mode_reg, mode_next;
    logic [SLEN_W-1:0]    slide_len_reg, slide_len_next;
    logic [SPOS_W-1:0]    slide_pos_reg, slide_pos_next;
    logic [SPOS_W:0]      slide_pos_inc;
    logic [SPOS_W:0]      slide_end;
    logic [DIGIT_W-1:0]   scan_index_reg, scan_index_next;
    logic [DIGIT_W-1:0]   shown_reg, shown_next;
    logic [7:0]           scan_count_reg, scan_count_next;
    logic [7:0]           duty_count_reg, duty_count_next;
    logic [7:0]           duty_load;
    logic [15:0]          slide_count_reg, slide_count_next;
    logic [15:0]          blink_count_reg, blink_count_next;
    logic [15:0]          timed_count_reg, timed_count_next;
    logic [PATTERN_W-1:0] blink_saved_reg, blink_saved_next;
    logic [DIGIT_W-1:0]   blink_index_reg, blink_index_next;
    logic                 blink_off_reg, blink_off_next;
    logic                 duty_off_reg, duty_off_next;
    logic [PATTERN_W-1:0] latched_reg, latched_next;

    // slide buffer
    logic                 ram_wr_en;
    logic [SLIDE_AW-1:0]  ram_wr_addr;
    logic [SLIDE_AW-1:0]  ram_rd_addr;
    logic [PATTERN_W-1:0] ram_rd_data;
    logic                 byp_hit_reg;
    logic [PATTERN_W-1:0] byp_data_reg;
    logic [PATTERN_W-1:0] slide_word;

    // output register
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;

    assign position = s_axis_tdata[4:0];
    assign pattern  = s_axis_tdata[12:5];
    assign amount   = s_axis_tdata[28:13];
    assign opcode   = op_t'(s_axis_tuser);

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign pos_clamped = (32'(position) > DIGITS - 1) ? DIGIT_W'(DIGITS - 1)
                                                      : DIGIT_W'(position);

    // ---------------------------------------------------------------- config
    assign bright_wr = (cfg_wdata[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : cfg_wdata[6:0];

    always_comb
    begin
        bright_next      = bright_reg;
        scan_ticks_next  = scan_ticks_reg;
        slide_ticks_next = slide_ticks_reg;
        blink_ticks_next = blink_ticks_reg;
        if (cfg_we)
        begin
            unique case (cfg_t'(cfg_index))
                CFG_BRIGHTNESS:  bright_next = bright_wr;
                CFG_SCAN_TICKS:  scan_ticks_next = (cfg_wdata[7:0] == 8'd0) ? 8'd1
                                                                              : cfg_wdata[7:0];
                CFG_SLIDE_TICKS: slide_ticks_next = (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
                CFG_BLINK_TICKS: blink_ticks_next = (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
                default: ;
            endcase
        end
        // keep the duty product in step with the registers it comes from
        prod_next = 15'(bright_next) * 15'(scan_ticks_next);
    end

    assign duty_full   = 28'(prod_reg) * 28'(DUTY_RECIP);
    assign duty_reload = 8'(duty_full >> DUTY_SHIFT);

    // ----------------------------------------------------------- slide buffer
    assign ram_wr_en   = accept && (opcode == OP_WRITE_SLIDE) && (32'(position) < SLIDE_DEPTH);
    assign ram_wr_addr = SLIDE_AW'(position);
    // prefetch the entry the next shift will need
    assign ram_rd_addr = slide_pos_next[SLIDE_AW-1:0];
    assign slide_word  = byp_hit_reg ? byp_data_reg : ram_rd_data;

    sssc_ram #(
        .WIDTH (PATTERN_W),
        .DEPTH (SLIDE_DEPTH)
    ) u_slide_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (pattern),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------ next state
    assign slide_pos_inc = {1'b0, slide_pos_reg} + (SPOS_W + 1)'(1);
    assign slide_end     = (SPOS_W + 1)'(slide_len_reg) + (SPOS_W + 1)'(DIGITS);

    always_comb
    begin
        digits_next      = digits_reg;
        mode_next        = mode_reg;
        slide_len_next   = slide_len_reg;
        slide_pos_next   = slide_pos_reg;
        scan_index_next  = scan_index_reg;
        shown_next       = shown_reg;
        scan_count_next  = scan_count_reg;
        duty_count_next  = duty_count_reg;
        slide_count_next = slide_count_reg;
        blink_count_next = blink_count_reg;
        timed_count_next = timed_count_reg;
        blink_saved_next = blink_saved_reg;
        blink_index_next = blink_index_reg;
        blink_off_next   = blink_off_reg;
        duty_off_next    = duty_off_reg;
        latched_next     = latched_reg;
        duty_load        = duty_count_reg;

        if (accept)
        begin
            unique case (opcode)
                OP_TICK:
                begin
                    // run the active mode
                    case (mode_reg)
                        MODE_TIMED:
                        begin
                            if (timed_count_reg == 16'd0)
                            begin
                                mode_next = MODE_SHOW;
                                for (int i = 0; i < DIGITS; i++)
                                begin
                                    digits_next[i] = '0;
                                end
                            end
                            else
                            begin
                                timed_count_next = timed_count_reg - 16'd1;
                            end
                        end
                        MODE_LOOP, MODE_ONCE:
                        begin
                            if (slide_count_reg == 16'd0)
                            begin
                                slide_count_next = slide_ticks_reg - 16'd1;
                                for (int i = 0; i < DIGITS - 1; i++)
                                begin
                                    digits_next[i] = digits_reg[i + 1];
                                end
                                digits_next[DIGITS-1] =
                                    ((SPOS_W + 1)'(slide_pos_reg) < (SPOS_W + 1)'(slide_len_reg))
                                    ? slide_word : '0;
                                slide_pos_next = SPOS_W'(slide_pos_inc);
                                if (slide_pos_inc >= slide_end)
                                begin
                                    if (mode_reg == MODE_ONCE)
                                    begin
                                        mode_next = MODE_SHOW;
                                    end
                                    else
                                    begin
                                        slide_pos_next = '0;
                                    end
                                end
                            end
                            else
                            begin
                                slide_count_next = slide_count_reg - 16'd1;
                            end
                        end
                        MODE_BLINK:
                        begin
                            if (blink_count_reg == 16'd0)
                            begin
                                digits_next[blink_index_reg] = blink_off_reg ? '0
                                                                             : blink_saved_reg;
                                blink_off_next   = !blink_off_reg;
                                blink_count_next = blink_ticks_reg - 16'd1;
                            end
                            else
                            begin
                                blink_count_next = blink_count_reg - 16'd1;
                            end
                        end
                        default: ;
                    endcase

                    // scan step, halted while brightness is zero
                    if (bright_reg != 7'd0)
                    begin
                        if (scan_count_reg == 8'd0)
                        begin
                            shown_next      = scan_index_reg;
                            latched_next    = digits_next[scan_index_reg];
                            scan_index_next = (scan_index_reg == DIGIT_W'(DIGITS - 1))
                                              ? '0 : scan_index_reg + DIGIT_W'(1);
                            scan_count_next = scan_ticks_reg - 8'd1;
                            duty_load       = duty_reload;
                            duty_off_next   = 1'b0;
                        end
                        else
                        begin
                            scan_count_next = scan_count_reg - 8'd1;
                        end
                        if (duty_load == 8'd0)
                        begin
                            duty_off_next   = 1'b1;
                            duty_count_next = duty_load;
                        end
                        else
                        begin
                            duty_count_next = duty_load - 8'd1;
                        end
                    end
                end
                OP_WRITE_DIGIT:
                begin
                    digits_next[pos_clamped] = pattern;
                end
                OP_WRITE_SLIDE: ;
                OP_TIMED:
                begin
                    mode_next        = MODE_TIMED;
                    timed_count_next = (amount == 16'd0) ? 16'd0 : amount - 16'd1;
                end
                OP_SLIDE_ONCE, OP_SLIDE_LOOP:
                begin
                    mode_next = (opcode == OP_SLIDE_ONCE) ? MODE_ONCE : MODE_LOOP;
                    slide_len_next = (32'(amount) > SLIDE_DEPTH) ? SLEN_W'(SLIDE_DEPTH)
                                                                 : SLEN_W'(amount);
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        digits_next[i] = '0;
                    end
                    slide_count_next = slide_ticks_reg - 16'd1;
                    slide_pos_next   = '0;
                end
                OP_SELECT:
                begin
                    mode_next = MODE_SELECT;
                    digits_next[pos_clamped] = digits_reg[pos_clamped] | 8'h01;
                end
                OP_BLINK:
                begin
                    mode_next        = MODE_BLINK;
                    blink_index_next = pos_clamped;
                    blink_saved_next = digits_reg[pos_clamped];
                    blink_count_next = blink_ticks_reg - 16'd1;
                    blink_off_next   = 1'b1;
                end
                OP_CLEAR:
                begin
                    mode_next = MODE_SHOW;
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        digits_next[i] = '0;
                    end
                end
                default: ;
            endcase
        end

        // drop the latched segments when brightness is written to zero
        if (cfg_we && (cfg_t'(cfg_index) == CFG_BRIGHTNESS) && (bright_wr == 7'd0))
        begin
            latched_next = '0;
        end
    end

    always_comb
    begin
        out_data_next = OUT_W'({mode_next,
                                duty_off_next ? {PATTERN_W{1'b0}} : latched_next,
                                shown_next});
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg      <= BRIGHT_RESET;
            scan_ticks_reg  <= SCAN_TICKS_RESET;
            slide_ticks_reg <= SLIDE_TICKS_RESET;
            blink_ticks_reg <= BLINK_TICKS_RESET;
            prod_reg        <= DUTY_PROD_RESET;
            for (int i = 0; i < DIGITS; i++)
            begin
                digits_reg[i] <= '0;
            end
            mode_reg        <= MODE_SHOW;
            slide_len_reg   <= '0;
            slide_pos_reg   <= '0;
            scan_index_reg  <= '0;
            shown_reg       <= '0;
            scan_count_reg  <= SCAN_TICKS_RESET - 8'd1;
            duty_count_reg  <= SCAN_TICKS_RESET - 8'd1;
            slide_count_reg <= SLIDE_TICKS_RESET - 16'd1;
            blink_count_reg <= BLINK_TICKS_RESET - 16'd1;
            timed_count_reg <= '0;
            blink_saved_reg <= '0;
            blink_index_reg <= '0;
            blink_off_reg   <= 1'b0;
            duty_off_reg    <= 1'b0;
            latched_reg     <= '0;
            byp_hit_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            bright_reg      <= bright_next;
            scan_ticks_reg  <= scan_ticks_next;
            slide_ticks_reg <= slide_ticks_next;
            blink_ticks_reg <= blink_ticks_next;
            prod_reg        <= prod_next;
            digits_reg      <= digits_next;
            mode_reg        <= mode_next;
            slide_len_reg   <= slide_len_next;
            slide_pos_reg   <= slide_pos_next;
            scan_index_reg  <= scan_index_next;
            shown_reg       <= shown_next;
            scan_count_reg  <= scan_count_next;
            duty_count_reg  <= duty_count_next;
            slide_count_reg <= slide_count_next;
            blink_count_reg <= blink_count_next;
            timed_count_reg <= timed_count_next;
            blink_saved_reg <= blink_saved_next;
            blink_index_reg <= blink_index_next;
            blink_off_reg   <= blink_off_next;
            duty_off_reg    <= duty_off_next;
            latched_reg     <= latched_next;
            // a write to the entry being prefetched overrides the stale RAM read
            byp_hit_reg     <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= pattern;
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: rtl/core/sssc_checker.sv
// Seven-segment scan controller: port checker and its bind.
// Watches the top level's ports only; depends on sssc_pkg.
module sssc_checker #(
    parameter int DIGITS = 4,
    parameter int OUT_W  = 16
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    import sssc_pkg::*;

    localparam int MODE_LSB = $clog2(DIGITS) + PATTERN_W;

    logic [MODE_W-1:0] mode_field;

    assign mode_field = m_axis_tdata[MODE_LSB +: MODE_W];

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or vanished");

    // every accepted item yields a result on the next cycle
    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted item produced no result");

    // no result without an item behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result appeared without an accepted item");

    // the mode field only carries defined modes
    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (mode_field <= MODE_BLINK))
        else $error("undefined mode on result");

endmodule

bind seven_segment_scan_controller_unit sssc_checker #(
    .DIGITS (DIGITS),
    .OUT_W  (OUT_W)
) u_sssc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/seven_segment_scan_controller_unit_test.sv
// Self-checking testbench for the seven-segment scan controller.
// It mirrors the scan, slide, blink and timed behaviour in a scoreboard class and
// compares every output item. Depends on sssc_pkg and the RTL top level.
module seven_segment_scan_controller_unit_test;

    import sssc_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          HOLD_OFF_CYCLES = 64;
    localparam logic [3:0]  OP_UNUSED_LO = 4'd9;
    localparam logic [3:0]  OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [1:0] digit_select;
        logic [7:0] segment_drive;
        logic [2:0] mode_now;
    } scan_view_t;

    class scan_output_tracker;
        logic [7:0]  digits [4];
        logic [7:0]  slides [32];
        int unsigned slide_len, slide_pos;
        mode_t       active_mode;
        logic [1:0]  scan_idx, shown_idx, blink_idx;
        int unsigned scan_cnt, duty_cnt, slide_cnt, blink_cnt, timed_cnt;
        logic [7:0]  blink_saved, latched;
        bit          blink_off, duty_off;
        int unsigned bright, scan_t, slide_t, blink_t;
        scan_view_t  awaited_views [$];
        int          mismatches;

        function new();
            bright = BRIGHT_RESET;
            scan_t = SCAN_TICKS_RESET;
            slide_t = SLIDE_TICKS_RESET;
            blink_t = BLINK_TICKS_RESET;
            blank_digits();
            foreach (slides[i]) slides[i] = '0;
            slide_len = 0;
            slide_pos = 0;
            active_mode = MODE_SHOW;
            scan_idx = '0;
            shown_idx = '0;
            blink_idx = '0;
            scan_cnt = scan_t - 1;
            duty_cnt = scan_t - 1;
            slide_cnt = slide_t - 1;
            blink_cnt = blink_t - 1;
            timed_cnt = 0;
            blink_saved = '0;
            latched = '0;
            blink_off = 0;
            duty_off = 0;
            mismatches = 0;
        endfunction

        function void blank_digits();
            foreach (digits[i]) digits[i] = '0;
        endfunction

        function logic [1:0] clamp_digit(logic [4:0] pos);
            return (pos > 5'd3) ? 2'd3 : pos[1:0];
        endfunction

        function int pending();
            return awaited_views.size();
        endfunction

        function void set_register(cfg_t idx, logic [15:0] val);
            case (idx)
                CFG_BRIGHTNESS:
                begin
                    bright = (val[6:0] > 7'd100) ? 100 : val[6:0];
                    if (bright == 0)
                        latched = '0;
                end
                CFG_SCAN_TICKS:  scan_t = (val[7:0] == 8'd0) ? 1 : val[7:0];
                CFG_SLIDE_TICKS: slide_t = (val == 16'd0) ? 1 : val;
                CFG_BLINK_TICKS: blink_t = (val == 16'd0) ? 1 : val;
                default: ;
            endcase
        endfunction

        // Advance the active mode, then the scan, as one tick does.
        function void run_tick();
            case (active_mode)
                MODE_TIMED:
                begin
                    if (timed_cnt == 0)
                    begin
                        active_mode = MODE_SHOW;
                        blank_digits();
                    end
                    else
                        timed_cnt--;
                end
                MODE_LOOP, MODE_ONCE:
                begin
                    if (slide_cnt == 0)
                    begin
                        slide_cnt = slide_t - 1;
                        for (int i = 0; i < 3; i++)
                            digits[i] = digits[i + 1];
                        digits[3] = (slide_pos < slide_len && slide_pos < 32) ?
                                    slides[slide_pos] : 8'h00;
                        slide_pos++;
                        if (slide_pos >= slide_len + 4)
                        begin
                            if (active_mode == MODE_ONCE)
                                active_mode = MODE_SHOW;
                            else
                                slide_pos = 0;
                        end
                    end
                    else
                        slide_cnt--;
                end
                MODE_BLINK:
                begin
                    if (blink_cnt == 0)
                    begin
                        digits[blink_idx] = blink_off ? 8'h00 : blink_saved;
                        blink_off = !blink_off;
                        blink_cnt = blink_t - 1;
                    end
                    else
                        blink_cnt--;
                end
                default: ;
            endcase

            if (bright != 0)
            begin
                if (scan_cnt == 0)
                begin
                    shown_idx = scan_idx;
                    latched = digits[scan_idx];
                    scan_idx = scan_idx + 2'd1;
                    scan_cnt = scan_t - 1;
                    duty_cnt = (bright * scan_t) / 100;
                    duty_off = 0;
                end
                else
                    scan_cnt--;
                if (duty_cnt == 0)
                    duty_off = 1;
                else
                    duty_cnt--;
            end
        endfunction

        function void take_item(logic [3:0] code, logic [4:0] pos, logic [7:0] pat,
                                logic [15:0] amt);
            scan_view_t view;
            logic [1:0] d;
            d = clamp_digit(pos);
            case (code)
                OP_TICK:        run_tick();
                OP_WRITE_DIGIT: digits[d] = pat;
                OP_WRITE_SLIDE: slides[pos] = pat;
                OP_TIMED:
                begin
                    active_mode = MODE_TIMED;
                    timed_cnt = (amt == 16'd0) ? 0 : amt - 1;
                end
                OP_SLIDE_ONCE, OP_SLIDE_LOOP:
                begin
                    active_mode = (code == OP_SLIDE_ONCE) ? MODE_ONCE : MODE_LOOP;
                    slide_len = (amt > 16'd32) ? 32 : amt;
                    blank_digits();
                    slide_cnt = slide_t - 1;
                    slide_pos = 0;
                end
                OP_SELECT:
                begin
                    active_mode = MODE_SELECT;
                    digits[d][0] = 1'b1;
                end
                OP_BLINK:
                begin
                    active_mode = MODE_BLINK;
                    blink_idx = d;
                    blink_saved = digits[d];
                    blink_cnt = blink_t - 1;
                    blink_off = 1;
                end
                OP_CLEAR:
                begin
                    active_mode = MODE_SHOW;
                    blank_digits();
                end
                default: ;
            endcase
            view.digit_select = shown_idx;
            view.segment_drive = duty_off ? 8'h00 : latched;
            view.mode_now = active_mode;
            awaited_views.push_back(view);
        endfunction

        function void match_output(logic [15:0] word);
            scan_view_t want;
            if (awaited_views.size() == 0)
            begin
                $error("output item 0x%04h arrived with nothing outstanding", word);
                mismatches++;
                return;
            end
            want = awaited_views.pop_front();
            if (word[1:0] !== want.digit_select)
            begin
                $error("digit_select: expected %0d, got %0d", want.digit_select, word[1:0]);
                mismatches++;
            end
            if (word[9:2] !== want.segment_drive)
            begin
                $error("segment_drive: expected 0x%02h, got 0x%02h",
                       want.segment_drive, word[9:2]);
                mismatches++;
            end
            if (word[12:10] !== want.mode_now)
            begin
                $error("mode_now: expected %0d, got %0d", want.mode_now, word[12:10]);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // position[4:0], pattern[12:5], amount[28:13]
    logic [3:0]  s_axis_tuser;   // opcode[3:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // digit_select[1:0], segment_drive[9:2], mode_now[12:10]
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    scan_output_tracker tracker;
    int items_sent;
    int src_gap_pct;
    int sink_gap_pct;
    int quiet_cycles;
    bit hold_off_request;

    seven_segment_scan_controller_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Note inputs before outputs so a result that appears together with its item would still find it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_item(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[12:5],
                                  s_axis_tdata[28:13]);
            if (m_axis_tvalid && m_axis_tready)
                tracker.match_output(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        @(negedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                hold_off_request = 0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);
                @(negedge clk);
            end
        end
    end

    // Entered and left at a falling edge; tvalid stays high for a following item.
    task automatic send_item(logic [3:0] code, logic [4:0] pos, logic [7:0] pat,
                             logic [15:0] amt);
        if (items_sent < 250)
        begin
            src_gap_pct = 25;
            sink_gap_pct = 79;
        end
        else if (items_sent < 500)
        begin
            src_gap_pct = 79;
            sink_gap_pct = 25;
        end
        else
        begin
            src_gap_pct = 0;
            sink_gap_pct = 0;
        end
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= code;
        s_axis_tdata <= {3'b000, amt, pat, pos};
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready))
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        tracker.set_register(idx, val);
        @(negedge clk);
    endtask

    // Drain, reprogram all four registers, then run random bursts.
    task automatic run_phase(logic [15:0] bright, logic [15:0] scan, logic [15:0] slide,
                             logic [15:0] blink, int n_items);
        int done;
        int r;
        logic [3:0] code;
        logic [15:0] amt;
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        write_reg(CFG_BRIGHTNESS, bright);
        write_reg(CFG_SCAN_TICKS, scan);
        write_reg(CFG_SLIDE_TICKS, slide);
        write_reg(CFG_BLINK_TICKS, blink);
        cfg_we <= 1'b0;
        done = 0;
        while (done < n_items)
        begin
            repeat ($urandom_range(0, 3))
            begin
                send_item(OP_WRITE_DIGIT, 5'($urandom_range(0, 31)),
                          8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
                done++;
            end
            r = $urandom_range(99);
            if (r < 20)      code = OP_WRITE_DIGIT;
            else if (r < 30) code = OP_WRITE_SLIDE;
            else if (r < 42) code = OP_TIMED;
            else if (r < 54) code = OP_SLIDE_ONCE;
            else if (r < 66) code = OP_SLIDE_LOOP;
            else if (r < 76) code = OP_SELECT;
            else if (r < 88) code = OP_BLINK;
            else if (r < 95) code = OP_CLEAR;
            else             code = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            if (code == OP_TIMED)
                amt = ($urandom_range(99) < 80) ? 16'($urandom_range(0, 30))
                                                : 16'($urandom_range(0, 65535));
            else
                amt = ($urandom_range(99) < 75) ? 16'($urandom_range(0, 40))
                                                : 16'($urandom_range(0, 65535));
            send_item(code, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)), amt);
            done++;
            repeat ($urandom_range(0, 30))
            begin
                send_item(OP_TICK, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
                done++;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        items_sent = 0;
        src_gap_pct = 0;
        sink_gap_pct = 0;
        quiet_cycles = 0;
        hold_off_request = 0;
        tracker = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill the whole slide buffer so no slide ever reads an unwritten entry.
        for (int i = 0; i < 32; i++)
            send_item(OP_WRITE_SLIDE, 5'(i), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)));

        // hold the receiver off while the directed items keep arriving
        hold_off_request = 1;
        send_item(OP_WRITE_DIGIT, 5'd0, 8'hFF, 16'h0000);
        send_item(OP_WRITE_DIGIT, 5'd31, 8'hA5, 16'hFFFF);
        send_item(OP_WRITE_DIGIT, 5'd1, 8'h00, 16'h0000);
        send_item(OP_WRITE_DIGIT, 5'd2, 8'h5A, 16'h0000);
        repeat (4) send_item(OP_TICK, 5'd31, 8'hFF, 16'hFFFF);
        send_item(OP_UNUSED_LO, 5'd0, 8'h00, 16'h0000);
        send_item(OP_UNUSED_HI, 5'd31, 8'hFF, 16'hFFFF);
        send_item(OP_SELECT, 5'd1, 8'h00, 16'h0000);
        send_item(OP_TICK, 5'd0, 8'h00, 16'h0000);
        send_item(OP_BLINK, 5'd3, 8'h00, 16'h0000);
        send_item(OP_TICK, 5'd0, 8'h00, 16'h0000);
        // zero duration acts as one tick: expire on the first tick
        send_item(OP_TIMED, 5'd0, 8'h00, 16'h0000);
        repeat (2) send_item(OP_TICK, 5'd0, 8'h00, 16'h0000);
        send_item(OP_TIMED, 5'd0, 8'h00, 16'hFFFF);
        send_item(OP_TICK, 5'd0, 8'h00, 16'h0000);
        send_item(OP_SLIDE_ONCE, 5'd0, 8'h00, 16'hFFFF);
        send_item(OP_TICK, 5'd0, 8'h00, 16'h0000);
        send_item(OP_SLIDE_LOOP, 5'd0, 8'h00, 16'h0000);
        send_item(OP_TICK, 5'd0, 8'h00, 16'h0000);
        send_item(OP_CLEAR, 5'd0, 8'h00, 16'h0000);
        send_item(OP_TICK, 5'd0, 8'h00, 16'h0000);

        run_phase(16'd100, 16'd1, 16'd1, 16'd1, 110);
        run_phase(16'd0, 16'd2, 16'd2, 16'd3, 110);
        run_phase(16'd127, 16'd255, 16'd65535, 16'd65535, 110);
        run_phase(16'd37, 16'd0, 16'd3, 16'd2, 110);
        run_phase(16'd1, 16'd4, 16'd0, 16'd0, 110);
        run_phase(16'($urandom_range(1, 127)), 16'($urandom_range(1, 10)),
                  16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)), 110);

        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
